// ===== src/positional_list_engine_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Positional list engine assertion macros
// Shorthand for the clocked, reset-qualified checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLE_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLE_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ple_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine package
// Sizes, codes and shared types of the linked list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

   // Pool size and element width.
   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;

   // Port field widths.
   localparam int POS_W     = 7;
   localparam int VAL_W     = 32;
   localparam int CNT_OUT_W = 7;

   // Derived internal widths.
   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam int RD_W   = (DATA_WIDTH < VAL_W) ? DATA_WIDTH : VAL_W;

   typedef logic [SLOT_W-1:0]     ple_slot_type;
   typedef logic [CNT_W-1:0]      ple_cnt_type;
   typedef logic [DATA_WIDTH-1:0] ple_data_type;

   typedef enum logic [2:0] {
      OP_INS_FIRST = 3'd0,
      OP_INS_LAST  = 3'd1,
      OP_INS_POS   = 3'd2,
      OP_DEL_FIRST = 3'd3,
      OP_DEL_LAST  = 3'd4,
      OP_DEL_POS   = 3'd5,
      OP_READ      = 3'd6
   } ple_op_type;

   typedef enum logic [1:0] {
      STS_OK     = 2'd0,
      STS_BADPOS = 2'd1,
      STS_EMPTY  = 2'd2,
      STS_FULL   = 2'd3
   } ple_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_PRIME,
      ST_WALK,
      ST_LINK_A,
      ST_LINK_B,
      ST_UNLINK,
      ST_DONE
   } ple_state_type;

   // Write commands to the three slot memories, one port each.
   typedef struct packed {
      logic         nxt_we;
      ple_slot_type nxt_addr;
      ple_slot_type nxt_data;
      logic         prv_we;
      ple_slot_type prv_addr;
      ple_slot_type prv_data;
      logic         elm_we;
      ple_slot_type elm_addr;
      ple_data_type elm_data;
   } ple_wr_type;

   // Registered read data of one slot.
   typedef struct packed {
      ple_slot_type nxt;
      ple_slot_type prv;
      ple_data_type elm;
   } ple_rd_type;

endpackage

// ===== src/positional_list_engine_unit.sv =====
`timescale 1ns / 1ps
`include "positional_list_engine_unit_assert.svh"
// ----------------------------------------------------------------------------
// Positional list engine
// Circular doubly linked list of signed values over a pool of slots.
// ----------------------------------------------------------------------------
// The engine takes one request at a time and returns exactly one response
// per request. After a request transfer it checks the request in state
// ST_CHECK; a rejected or unused request goes straight to the response. An
// insert then scans the free-slot map one slot per cycle, from slot 0 up to
// the lowest free slot, and any operation on a non-empty list walks the
// next links from the head, one slot per cycle (a read of the head is
// primed first, then the walk steps on to the k-th position; inserts at
// the back walk only to the head). A new element is linked in ST_LINK_A
// and ST_LINK_B, and an element is unlinked in ST_UNLINK. The free-slot
// scan and the link walk, one step per cycle, set the latency. The worst
// case is an insert that finds only the last slot free and walks to the
// next-to-last position. The next request can be taken in the cycle
// after the response transfer. req_ready is high only while the engine is
// idle, that is after the previous response has been taken.
module positional_list_engine_unit
   import ple_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_opcode,
   input  logic signed [VAL_W-1:0]     req_value,
   input  logic [POS_W-1:0]            req_position,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [CNT_OUT_W-1:0]        rsp_element_count,
   output logic signed [VAL_W-1:0]     rsp_read_value
);

   ple_state_type  state_ff, state_in;
   ple_op_type     op_ff, op_in;
   ple_data_type   val_ff, val_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   ple_status_type sts_ff, sts_in;
   logic [VAL_W-1:0] rd_ff, rd_in;
   ple_cnt_type    count_ff, count_in;
   ple_slot_type   head_ff, head_in;
   logic [CAPACITY-1:0] free_ff, free_in;
   ple_cnt_type    step_ff, step_in;
   ple_cnt_type    tgt_ff, tgt_in;
   logic           front_ff, front_in;
   ple_slot_type   n_ff, n_in;
   ple_slot_type   a_ff, a_in;
   ple_slot_type   b_ff, b_in;
   ple_slot_type   cur_ff, cur_in;

   ple_slot_type   rd_addr;
   ple_wr_type     wr;
   ple_rd_type     rd_data;

   logic           is_ins, is_del, is_read;
   logic           chk_act;
   ple_status_type chk_status;
   ple_cnt_type    chk_epos;
   ple_cnt_type    chk_tgt;
   ple_cnt_type    count_inc;
   logic [CMP_W-1:0] pos_ext, cnt_ext;
   logic           full, empty, ins_bad, acc_bad;
   logic           step_hit;
   logic           scan_hit;
   logic [VAL_W-1:0] elm_out;

   ple_store u_store (
      .clock   (clock),
      .rd_addr (rd_addr),
      .wr      (wr),
      .rd_data (rd_data)
   );

   // Operation class of the held request.
   always_comb begin
      is_ins  = (op_ff == OP_INS_FIRST) || (op_ff == OP_INS_LAST) ||
                (op_ff == OP_INS_POS);
      is_del  = (op_ff == OP_DEL_FIRST) || (op_ff == OP_DEL_LAST) ||
                (op_ff == OP_DEL_POS);
      is_read = (op_ff == OP_READ);
   end

   // Request check: status, effective position and walk target.
   always_comb begin
      count_inc  = count_ff + 1'b1;
      pos_ext    = CMP_W'(pos_ff);
      cnt_ext    = CMP_W'(count_ff);
      full       = (count_ff == CNT_W'(CAPACITY));
      empty      = (count_ff == '0);
      ins_bad    = (pos_ext == '0) || (pos_ext > (cnt_ext + CMP_W'(1)));
      acc_bad    = (pos_ext == '0) || (pos_ext > cnt_ext);
      chk_status = STS_OK;
      chk_act    = 1'b0;
      chk_epos   = CNT_W'(1);
      unique case (op_ff)
         OP_INS_FIRST: begin
            if (full) chk_status = STS_FULL;
            else      chk_act    = 1'b1;
         end
         OP_INS_LAST: begin
            chk_epos = count_inc;
            if (full) chk_status = STS_FULL;
            else      chk_act    = 1'b1;
         end
         OP_INS_POS: begin
            chk_epos = CNT_W'(pos_ff);
            if (ins_bad)   chk_status = STS_BADPOS;
            else if (full) chk_status = STS_FULL;
            else           chk_act    = 1'b1;
         end
         OP_DEL_FIRST: begin
            if (empty) chk_status = STS_EMPTY;
            else       chk_act    = 1'b1;
         end
         OP_DEL_LAST: begin
            chk_epos = count_ff;
            if (empty) chk_status = STS_EMPTY;
            else       chk_act    = 1'b1;
         end
         OP_DEL_POS, OP_READ: begin
            chk_epos = CNT_W'(pos_ff);
            if (acc_bad) chk_status = STS_BADPOS;
            else         chk_act    = 1'b1;
         end
         default: begin
            chk_act = 1'b0;
         end
      endcase
      // An insert behind the last element links in front of the head.
      chk_tgt = (is_ins && (chk_epos == count_inc)) ? CNT_W'(1) : chk_epos;
   end

   // Shared step counter compare and free-slot probe.
   always_comb begin
      step_hit = (step_ff == tgt_ff);
      scan_hit = free_ff[step_ff[SLOT_W-1:0]];
      elm_out  = '0;
      elm_out[RD_W-1:0] = rd_data.elm[RD_W-1:0];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!chk_act)    state_in = ST_DONE;
            else if (is_ins) state_in = ST_SCAN;
            else             state_in = ST_PRIME;
         end
         ST_SCAN: begin
            if (scan_hit) state_in = empty ? ST_LINK_A : ST_PRIME;
         end
         ST_PRIME: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (step_hit) begin
               if (is_ins)      state_in = ST_LINK_A;
               else if (is_del) state_in = ST_UNLINK;
               else             state_in = ST_DONE;
            end
         end
         ST_LINK_A: begin
            state_in = ST_LINK_B;
         end
         ST_LINK_B, ST_UNLINK: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath, memory commands and list bookkeeping.
   always_comb begin
      op_in    = op_ff;
      val_in   = val_ff;
      pos_in   = pos_ff;
      sts_in   = sts_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      head_in  = head_ff;
      free_in  = free_ff;
      step_in  = step_ff;
      tgt_in   = tgt_ff;
      front_in = front_ff;
      n_in     = n_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      cur_in   = cur_ff;
      rd_addr  = cur_ff;
      wr       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in  = ple_op_type'(req_opcode);
               val_in = DATA_WIDTH'(req_value);
               pos_in = req_position;
            end
         end
         ST_CHECK: begin
            sts_in   = chk_status;
            rd_in    = '0;
            tgt_in   = chk_tgt;
            front_in = (chk_epos == CNT_W'(1));
            step_in  = '0;
         end
         ST_SCAN: begin
            // An empty list links the new slot to itself.
            if (scan_hit) begin
               n_in   = step_ff[SLOT_W-1:0];
               a_in   = step_ff[SLOT_W-1:0];
               cur_in = step_ff[SLOT_W-1:0];
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_PRIME: begin
            rd_addr = head_ff;
            cur_in  = head_ff;
            step_in = CNT_W'(1);
         end
         ST_WALK: begin
            // Read data always belongs to the current slot here.
            if (step_hit) begin
               a_in = rd_data.prv;
               b_in = rd_data.nxt;
               if (is_read) rd_in = elm_out;
            end else begin
               cur_in  = rd_data.nxt;
               rd_addr = rd_data.nxt;
               step_in = step_ff + 1'b1;
            end
         end
         ST_LINK_A: begin
            wr.nxt_we   = 1'b1;
            wr.nxt_addr = a_ff;
            wr.nxt_data = n_ff;
            wr.prv_we   = 1'b1;
            wr.prv_addr = n_ff;
            wr.prv_data = a_ff;
            wr.elm_we   = 1'b1;
            wr.elm_addr = n_ff;
            wr.elm_data = val_ff;
         end
         ST_LINK_B: begin
            wr.nxt_we   = 1'b1;
            wr.nxt_addr = n_ff;
            wr.nxt_data = cur_ff;
            wr.prv_we   = 1'b1;
            wr.prv_addr = cur_ff;
            wr.prv_data = n_ff;
            if (front_ff) head_in = n_ff;
            free_in[n_ff] = 1'b0;
            count_in      = count_inc;
         end
         ST_UNLINK: begin
            if (count_ff == CNT_W'(1)) begin
               head_in = '0;
            end else begin
               wr.nxt_we   = 1'b1;
               wr.nxt_addr = a_ff;
               wr.nxt_data = b_ff;
               wr.prv_we   = 1'b1;
               wr.prv_addr = b_ff;
               wr.prv_data = a_ff;
               if (front_ff) head_in = b_ff;
            end
            free_in[cur_ff] = 1'b1;
            count_in        = count_ff - 1'b1;
         end
         ST_DONE: begin
            rd_addr = cur_ff;
         end
         default: begin
            rd_addr = cur_ff;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         head_ff  <= '0;
         free_ff  <= '1;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         head_ff  <= head_in;
         free_ff  <= free_in;
      end
   end

   // Request payload and work registers.
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      val_ff   <= val_in;
      pos_ff   <= pos_in;
      sts_ff   <= sts_in;
      rd_ff    <= rd_in;
      step_ff  <= step_in;
      tgt_ff   <= tgt_in;
      front_ff <= front_in;
      n_ff     <= n_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      cur_ff   <= cur_in;
   end

   // Handshake and response outputs.
   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = (state_ff == ST_DONE);
   assign rsp_status        = sts_ff;
   assign rsp_element_count = CNT_OUT_W'(count_ff);
   assign rsp_read_value    = rd_ff;

   // Free map and element count always account for every slot when idle.
   `PLE_ASSERT_IMP(a_free_count, state_ff == ST_IDLE, $countones(free_ff) + int'(count_ff) == CAPACITY, "free slots and element count disagree")
   // The slot being linked in must still be free.
   `PLE_ASSERT_IMP(a_link_free, state_ff == ST_LINK_B, free_ff[n_ff], "linking a slot that is in use")
   // The slot being unlinked must be in use.
   `PLE_ASSERT_IMP(a_unlink_used, state_ff == ST_UNLINK, !free_ff[cur_ff], "unlinking a free slot")
   // The count changes only when a slot is linked or unlinked.
   `PLE_ASSERT_NXT(a_count_hold, state_ff != ST_LINK_B && state_ff != ST_UNLINK, count_ff == $past(count_ff), "element count changed outside link or unlink")
   // The count never exceeds the pool size.
   `PLE_ASSERT_IMP(a_count_max, 1'b1, count_ff <= CNT_W'(CAPACITY), "element count above capacity")

endmodule

// ===== src/ple_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine slot store
// Element, next-link and previous-link memories with one shared read address.
// ----------------------------------------------------------------------------
module ple_store
   import ple_pkg::*;
(
   input  logic         clock,
   input  ple_slot_type rd_addr,
   input  ple_wr_type   wr,
   output ple_rd_type   rd_data
);

   ple_slot_type nxt_mem [CAPACITY];
   ple_slot_type prv_mem [CAPACITY];
   ple_data_type elm_mem [CAPACITY];
   ple_rd_type   rd_ff;

   // Each memory takes at most one write per cycle.
   always_ff @(posedge clock) begin
      if (wr.nxt_we) begin
         nxt_mem[wr.nxt_addr] <= wr.nxt_data;
      end
      if (wr.prv_we) begin
         prv_mem[wr.prv_addr] <= wr.prv_data;
      end
      if (wr.elm_we) begin
         elm_mem[wr.elm_addr] <= wr.elm_data;
      end
   end

   // All three memories are read at the same slot; data is registered.
   always_ff @(posedge clock) begin
      rd_ff.nxt <= nxt_mem[rd_addr];
      rd_ff.prv <= prv_mem[rd_addr];
      rd_ff.elm <= elm_mem[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

// ===== bench/positional_list_engine_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Drives list operations through the request channel with random gaps on
// both sides, keeps an ordered shadow copy of the list, and checks every
// response field against that copy or, for pinned script rows, the script.
// ----------------------------------------------------------------------------
module positional_list_engine_unit_tb;
   import ple_pkg::*;

   // Opcode 7 has no operation behind it and must leave the list alone.
   localparam logic [2:0] OP_UNUSED = 3'd7;

   localparam int RANDOM_ITEMS = 1350;
   localparam int SCRIPT_LEN   = 25;
   localparam int MAX_GAP      = 16;
   localparam int SETTLE       = 2 * CAPACITY + 16;

   typedef enum int {
      MIX_GROW,
      MIX_BALANCED,
      MIX_SHRINK
   } traffic_mix_type;

   typedef struct packed {
      ple_status_type          status;
      logic [CNT_OUT_W-1:0]    count;
      logic signed [VAL_W-1:0] rdval;
   } list_result_type;

   typedef struct packed {
      logic [2:0]              op;
      logic signed [VAL_W-1:0] val;
      logic [POS_W-1:0]        pos;
      bit                      pinned;
      ple_status_type          status;
      logic [CNT_OUT_W-1:0]    count;
      logic signed [VAL_W-1:0] rdval;
   } script_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [2:0]              req_opcode = OP_UNUSED;
   logic signed [VAL_W-1:0] req_value = '0;
   logic [POS_W-1:0]        req_position = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [1:0]              rsp_status;
   logic [CNT_OUT_W-1:0]    rsp_element_count;
   logic signed [VAL_W-1:0] rsp_read_value;

   // Shadow list in list order, and results still owed by the engine.
   logic signed [VAL_W-1:0] shadow_list [$];
   list_result_type         owed_results [$];
   int                      mismatch_count = 0;

   // Expectation typed into the opening script for the current request.
   bit                      pin_on = 1'b0;
   list_result_type         pin_result = '0;
   bit                      sender_calm = 1'b0;

   // Opening script: empty-list errors, value extremes, bad positions.
   script_row_type opening_script [SCRIPT_LEN] = '{
      '{OP_DEL_FIRST, 32'sd0,          7'd0,   1'b1, STS_EMPTY,  7'd0, 32'sd0},
      '{OP_DEL_LAST,  32'sd0,          7'd0,   1'b1, STS_EMPTY,  7'd0, 32'sd0},
      '{OP_DEL_POS,   32'sd0,          7'd1,   1'b1, STS_BADPOS, 7'd0, 32'sd0},
      '{OP_READ,      32'sd0,          7'd1,   1'b1, STS_BADPOS, 7'd0, 32'sd0},
      '{OP_INS_POS,   32'sd5,          7'd0,   1'b1, STS_BADPOS, 7'd0, 32'sd0},
      '{OP_INS_POS,   32'sd5,          7'd2,   1'b1, STS_BADPOS, 7'd0, 32'sd0},
      '{OP_UNUSED,    32'shFFFF_FFFF,  7'd127, 1'b1, STS_OK,     7'd0, 32'sd0},
      '{OP_INS_FIRST, 32'sh7FFF_FFFF,  7'd0,   1'b1, STS_OK,     7'd1, 32'sd0},
      '{OP_INS_LAST,  32'sh8000_0000,  7'd127, 1'b1, STS_OK,     7'd2, 32'sd0},
      '{OP_READ,      32'sd0,          7'd1,   1'b1, STS_OK,     7'd2, 32'sh7FFF_FFFF},
      '{OP_READ,      32'sd0,          7'd2,   1'b1, STS_OK,     7'd2, 32'sh8000_0000},
      '{OP_READ,      32'sd0,          7'd3,   1'b1, STS_BADPOS, 7'd2, 32'sd0},
      '{OP_READ,      32'sd0,          7'd127, 1'b1, STS_BADPOS, 7'd2, 32'sd0},
      '{OP_INS_POS,   32'sd0,          7'd2,   1'b0, STS_OK,     7'd0, 32'sd0},
      '{OP_INS_POS,   32'shFFFF_FFFF,  7'd4,   1'b0, STS_OK,     7'd0, 32'sd0},
      '{OP_INS_POS,   32'sd9,          7'd6,   1'b1, STS_BADPOS, 7'd4, 32'sd0},
      '{OP_READ,      32'sd0,          7'd4,   1'b0, STS_OK,     7'd0, 32'sd0},
      '{OP_DEL_POS,   32'sd0,          7'd2,   1'b0, STS_OK,     7'd0, 32'sd0},
      '{OP_DEL_POS,   32'sd0,          7'd4,   1'b1, STS_BADPOS, 7'd3, 32'sd0},
      '{OP_DEL_POS,   32'sd0,          7'd0,   1'b1, STS_BADPOS, 7'd3, 32'sd0},
      '{OP_DEL_FIRST, 32'sd0,          7'd0,   1'b0, STS_OK,     7'd0, 32'sd0},
      '{OP_DEL_LAST,  32'sd0,          7'd0,   1'b0, STS_OK,     7'd0, 32'sd0},
      '{OP_READ,      32'sd0,          7'd1,   1'b0, STS_OK,     7'd0, 32'sd0},
      '{OP_INS_POS,   32'sh5555_5555,  7'd1,   1'b0, STS_OK,     7'd0, 32'sd0},
      '{OP_UNUSED,    32'sh2AAA_AAAA,  7'd64,  1'b0, STS_OK,     7'd0, 32'sd0}
   };

   positional_list_engine_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_value         (req_value),
      .req_position      (req_position),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count),
      .rsp_read_value    (rsp_read_value)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one operation to the shadow list and returns the response it owes.
   function automatic list_result_type apply_list_op(input logic [2:0] op,
                                                     input logic signed [VAL_W-1:0] val,
                                                     input logic [POS_W-1:0] pos);
      list_result_type res;
      int              n;
      int              p;
      n = shadow_list.size();
      p = pos;
      res.status = STS_OK;
      res.rdval  = '0;
      case (op)
         OP_INS_FIRST: begin
            if (n >= CAPACITY) res.status = STS_FULL;
            else shadow_list.push_front(val);
         end
         OP_INS_LAST: begin
            if (n >= CAPACITY) res.status = STS_FULL;
            else shadow_list.push_back(val);
         end
         OP_INS_POS: begin
            // A bad position wins over a full list.
            if (p < 1 || p > n + 1) res.status = STS_BADPOS;
            else if (n >= CAPACITY) res.status = STS_FULL;
            else shadow_list.insert(p - 1, val);
         end
         OP_DEL_FIRST: begin
            if (n == 0) res.status = STS_EMPTY;
            else void'(shadow_list.pop_front());
         end
         OP_DEL_LAST: begin
            if (n == 0) res.status = STS_EMPTY;
            else void'(shadow_list.pop_back());
         end
         OP_DEL_POS: begin
            if (p < 1 || p > n) res.status = STS_BADPOS;
            else shadow_list.delete(p - 1);
         end
         OP_READ: begin
            if (p < 1 || p > n) res.status = STS_BADPOS;
            else res.rdval = shadow_list[p - 1];
         end
         default: ;
      endcase
      res.count = CNT_OUT_W'(shadow_list.size());
      return res;
   endfunction

   // Checks each response transfer, then records each request transfer.
   always @(posedge clock) begin
      list_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (owed_results.size() == 0) begin
               $display("%0t: response with none pending: status %0d count %0d value %0d",
                        $time, rsp_status, rsp_element_count, rsp_read_value);
               mismatch_count++;
            end else begin
               want = owed_results.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_element_count !== want.count) begin
                  $display("%0t: element_count expected %0d actual %0d",
                           $time, want.count, rsp_element_count);
                  mismatch_count++;
               end
               if (rsp_read_value !== want.rdval) begin
                  $display("%0t: read_value expected %0d actual %0d",
                           $time, want.rdval, rsp_read_value);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            want = apply_list_op(req_opcode, req_value, req_position);
            if (pin_on) want = pin_result;
            owed_results.push_back(want);
         end
      end
   end

   // Response side: random stalls per transfer, with calm stretches.
   initial begin
      int gap;
      bit calm;
      calm = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 63) == 0) calm = !calm;
         gap = calm ? 0 : $urandom_range(0, MAX_GAP);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Presents one request after a random gap and holds it until the transfer.
   task automatic send_request(input logic [2:0] op, input logic signed [VAL_W-1:0] val,
                               input logic [POS_W-1:0] pos, input bit pinned,
                               input list_result_type pinned_result);
      int gap;
      if ($urandom_range(0, 63) == 0) sender_calm = !sender_calm;
      gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_opcode   <= op;
      req_value    <= val;
      req_position <= pos;
      req_valid    <= 1'b1;
      pin_on       = pinned;
      pin_result   = pinned_result;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   // Holds off new requests until every owed response has come back.
   task automatic drain_responses;
      req_valid <= 1'b0;
      do @(negedge clock); while (owed_results.size() != 0);
   endtask

   // Picks a mostly well-formed request for the given traffic mix.
   task automatic choose_request(input traffic_mix_type mix, output logic [2:0] op,
                                 output logic signed [VAL_W-1:0] val,
                                 output logic [POS_W-1:0] pos);
      int n;
      int roll;
      int ins_w;
      int del_w;
      n = shadow_list.size();
      val = $urandom();
      pos = POS_W'($urandom_range(0, 127));
      case (mix)
         MIX_GROW:   begin ins_w = 75; del_w = 10; end
         MIX_SHRINK: begin ins_w = 10; del_w = 75; end
         default:    begin ins_w = 40; del_w = 40; end
      endcase
      roll = $urandom_range(0, 109);
      if (roll >= 100) begin
         // Noise: any opcode and any position.
         op = 3'($urandom_range(0, 7));
      end else if (roll < ins_w) begin
         op = 3'($urandom_range(OP_INS_FIRST, OP_INS_POS));
         pos = POS_W'($urandom_range(1, n + 1));
      end else if (roll < ins_w + del_w) begin
         op = 3'($urandom_range(OP_DEL_FIRST, OP_DEL_POS));
         if (n > 0) pos = POS_W'($urandom_range(1, n));
      end else begin
         op = OP_READ;
         if (n > 0) pos = POS_W'($urandom_range(1, n));
      end
   endtask

   // Stimulus: opening script, then phases that fill, churn and empty the list.
   initial begin
      int                      sent;
      int                      phase;
      int                      len;
      int                      extra;
      bit                      phase_done;
      traffic_mix_type         mix;
      logic [2:0]              op;
      logic signed [VAL_W-1:0] val;
      logic [POS_W-1:0]        pos;
      script_row_type          row;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < SCRIPT_LEN; i++) begin
         row = opening_script[i];
         send_request(row.op, row.val, row.pos, row.pinned,
                      '{row.status, row.count, row.rdval});
      end
      drain_responses();

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         case (phase % 4)
            0:       mix = MIX_GROW;
            2:       mix = MIX_SHRINK;
            default: mix = MIX_BALANCED;
         endcase
         len = 0;
         extra = 0;
         phase_done = 1'b0;
         while (!phase_done && sent < RANDOM_ITEMS) begin
            choose_request(mix, op, val, pos);
            send_request(op, val, pos, 1'b0, '0);
            sent++;
            len++;
            // Linger a few items at the full or empty boundary.
            if (mix == MIX_GROW && shadow_list.size() == CAPACITY) extra++;
            if (mix == MIX_SHRINK && shadow_list.size() == 0) extra++;
            if (mix == MIX_BALANCED) phase_done = (len >= 120);
            else phase_done = (extra >= 8 || len >= 400);
         end
         drain_responses();
         phase++;
      end

      repeat (SETTLE) @(negedge clock);
      if (mismatch_count == 0 && owed_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
